// ----- rtl/crc64_prefix_match_search_core_defines.svh -----
// Assertion macros for the CRC-64 prefix match search core.
`ifndef CRC64_PREFIX_MATCH_SEARCH_CORE_DEFINES_SVH
`define CRC64_PREFIX_MATCH_SEARCH_CORE_DEFINES_SVH

// Clocked property, disabled while in reset.
`define CPMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Held-valid check for a stalled channel.
`define CPMS_ASSERT_HOLD(lbl, vld, stl, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && stl) |=> vld) \
    else $error(msg);

`endif

// ----- rtl/cpms_pkg.sv -----
// Shared types and constants for the CRC-64 prefix match search core.
package cpms_pkg;

  localparam int CRC_W          = 64;
  localparam int BYTE_W         = 8;
  localparam int MATCH_LEN_W    = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CRC_W-1:0] POLY_RESET = 64'h42F0_E1EB_A9EA_3693;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL  = 2'd0,
    REG_QUERY_VALUE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CRC_W-1:0]       crc_value;
    logic                   match_now;
    logic                   found;
    logic [MATCH_LEN_W-1:0] match_length;
  } result_t;

endpackage

// ----- rtl/cpms_crc_byte.sv -----
// One-byte reflected CRC-64 update with a runtime polynomial.
module cpms_crc_byte
  import cpms_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data_in,
  input  logic [CRC_W-1:0]  poly,
  output logic [CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// ----- rtl/crc64_prefix_match_search_core.sv -----
// CRC-64 prefix match search core: running CRC, query compare, first-match latch.
// Each result is registered in the output register, or the skid buffer if that is stalled.
// Throughput: one byte per cycle unless stalled; eight shift-xor CRC steps are combinational.
// A one-entry skid buffer takes one more transaction while a result is stalled; in_stall is
// high while it is full. Reset (rst_n low, synchronous) clears CRC, count, found flag, length
// and both buffers, and loads the polynomial with 0x42F0E1EBA9EA3693 and the query with zero.
module crc64_prefix_match_search_core
  import cpms_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CRC_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      in_data_byte,
  input  logic                   in_start_req,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CRC_W-1:0]       out_crc_value,
  output logic                   out_match_now,
  output logic                   out_found,
  output logic [MATCH_LEN_W-1:0] out_match_length
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [CRC_W-1:0]      poly_r;
  logic [CRC_W-1:0]      query_r;
  logic [CRC_W-1:0]      crc_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  found_r;
  logic [COUNT_BITS-1:0] len_r;

  logic [CRC_W-1:0]       crc_base;
  logic [COUNT_BITS-1:0]  count_base;
  logic                   found_base;
  logic [COUNT_BITS-1:0]  len_base;
  logic [CRC_W-1:0]       crc_nxt;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic                   found_nxt;
  logic [COUNT_BITS-1:0]  len_nxt;
  logic                   hit;
  logic [MATCH_LEN_W-1:0] len_out;

  result_t res;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;
  logic    in_accept;
  logic    out_free;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid & ~skid_valid_r;
  assign out_free  = ~out_valid_r | ~out_stall;

  assign crc_base   = in_start_req ? '0 : crc_r;
  assign count_base = in_start_req ? '0 : count_r;
  assign found_base = in_start_req ? 1'b0 : found_r;
  assign len_base   = in_start_req ? '0 : len_r;

  cpms_crc_byte u_crc_byte (
    .crc_in  (crc_base),
    .data_in (in_data_byte),
    .poly    (poly_r),
    .crc_out (crc_nxt)
  );

  assign count_nxt = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
  assign hit       = (crc_nxt == query_r);
  assign found_nxt = found_base | hit;
  assign len_nxt   = (hit & ~found_base) ? count_nxt : len_base;

  generate
    if (COUNT_BITS >= MATCH_LEN_W) begin : g_len_trunc
      assign len_out = len_nxt[MATCH_LEN_W-1:0];
    end else begin : g_len_ext
      assign len_out = {{(MATCH_LEN_W-COUNT_BITS){1'b0}}, len_nxt};
    end
  endgenerate

  always_comb begin
    res.crc_value    = crc_nxt;
    res.match_now    = hit;
    res.found        = found_nxt;
    res.match_length = len_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r       <= POLY_RESET;
      query_r      <= '0;
      crc_r        <= '0;
      count_r      <= '0;
      found_r      <= 1'b0;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLYNOMIAL:  poly_r  <= cfg_data;
          REG_QUERY_VALUE: query_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        crc_r   <= crc_nxt;
        count_r <= count_nxt;
        found_r <= found_nxt;
        len_r   <= len_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_accept;
        end
      end else if (in_accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= res;
      end
    end else if (in_accept) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_crc_value    = out_r.crc_value;
  assign out_match_now    = out_r.match_now;
  assign out_found        = out_r.found;
  assign out_match_length = out_r.match_length;

endmodule

// ----- rtl/cpms_checker.sv -----
// Port-level checker for the CRC-64 prefix match search core, with its bind.
`include "crc64_prefix_match_search_core_defines.svh"

module cpms_checker
  import cpms_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [CRC_W-1:0]       out_crc_value,
  input logic                   out_match_now,
  input logic                   out_found,
  input logic [MATCH_LEN_W-1:0] out_match_length
);

  logic                               out_hold;
  logic                               no_found;
  logic [CRC_W+MATCH_LEN_W+1:0]       out_bits;

  assign out_hold = out_valid && out_stall;
  assign no_found = out_valid && !out_found;
  assign out_bits = {out_crc_value, out_match_now, out_found, out_match_length};

  `CPMS_ASSERT_HOLD(a_in_valid_hold, in_valid, in_stall, "transaction dropped while stalled")
  `CPMS_ASSERT_HOLD(a_out_valid_hold, out_valid, out_stall, "result dropped while stalled")
  `CPMS_ASSERT(a_out_payload_hold, out_hold |=> $stable(out_bits), "stalled result changed")
  `CPMS_ASSERT(a_match_sets_found, (out_valid && out_match_now) |-> out_found, "match, no found")
  `CPMS_ASSERT(a_no_found_no_len, no_found |-> (out_match_length == '0), "length without match")

endmodule

bind crc64_prefix_match_search_core cpms_checker u_cpms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_crc_value    (out_crc_value),
  .out_match_now    (out_match_now),
  .out_found        (out_found),
  .out_match_length (out_match_length)
);

// ----- tb/sv/crc64_prefix_match_search_core_tb.sv -----
// Testbench for the CRC-64 prefix match search core: directed and random byte streams.
module crc64_prefix_match_search_core_tb;
  import cpms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int TARGET_BYTES = 1450;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } byte_txn_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CRC_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_data_byte;
  logic                   in_start_req;
  logic                   out_valid;
  logic                   out_stall;
  logic [CRC_W-1:0]       out_crc_value;
  logic                   out_match_now;
  logic                   out_found;
  logic [MATCH_LEN_W-1:0] out_match_length;

  crc64_prefix_match_search_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_req     (in_start_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_crc_value    (out_crc_value),
    .out_match_now    (out_match_now),
    .out_found        (out_found),
    .out_match_length (out_match_length)
  );

  byte_txn_t pending_bytes[$];
  result_t   expected_results[$];
  int        queued_cnt;
  int        accepted_cnt;
  int        mismatches;
  bit        in_took;
  bit        steady;
  int        idle_left;
  int        stall_left;

  logic [CRC_W-1:0]          poly_cfg;
  logic [CRC_W-1:0]          query_cfg;
  logic [CRC_W-1:0]          search_crc;
  logic [COUNT_BITS_DEF-1:0] search_count;
  logic                      search_found;
  logic [COUNT_BITS_DEF-1:0] search_len;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [CRC_W-1:0] crc_next_byte(input logic [CRC_W-1:0] c,
                                                      input logic [BYTE_W-1:0] b,
                                                      input logic [CRC_W-1:0] p);
    logic [CRC_W-1:0] v;
    int               k;
    v = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ p) : (v >> 1);
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [CRC_W-1:0] got,
                                 input logic [CRC_W-1:0] want);
    $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic track_byte(input logic [BYTE_W-1:0] b, input logic st);
    result_t r;
    if (st) begin
      search_crc   = '0;
      search_count = '0;
      search_found = 1'b0;
      search_len   = '0;
    end
    search_crc = crc_next_byte(search_crc, b, poly_cfg);
    if (search_count != '1) search_count++;
    r.match_now = (search_crc == query_cfg);
    if (r.match_now && !search_found) begin
      search_found = 1'b1;
      search_len   = search_count;
    end
    r.crc_value    = search_crc;
    r.found        = search_found;
    r.match_length = search_len[MATCH_LEN_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_POLYNOMIAL:  poly_cfg = val;
      REG_QUERY_VALUE: query_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_byte(input logic [BYTE_W-1:0] b, input logic st);
    byte_txn_t t;
    t.data  = b;
    t.start = st;
    pending_bytes.push_back(t);
    queued_cnt++;
  endtask

  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_results.size() != 0) @(negedge clk);
  endtask

  // transaction driver
  always @(negedge clk) begin
    byte_txn_t t;
    if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        t = pending_bytes.pop_front();
        in_data_byte <= t.data;
        in_start_req <= t.start;
        in_valid     <= 1'b1;
        idle_left = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      track_byte(in_data_byte, in_start_req);
      accepted_cnt++;
      in_took = 1'b1;
    end
  end

  // result stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b1;
      stall_left--;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result without transaction", out_crc_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_crc_value !== want.crc_value)
          report_mismatch("crc_value", out_crc_value, want.crc_value);
        if (out_match_now !== want.match_now)
          report_mismatch("match_now", CRC_W'(out_match_now), CRC_W'(want.match_now));
        if (out_found !== want.found)
          report_mismatch("found", CRC_W'(out_found), CRC_W'(want.found));
        if (out_match_length !== want.match_length)
          report_mismatch("match_length", CRC_W'(out_match_length),
                          CRC_W'(want.match_length));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [BYTE_W-1:0] prefix [0:15];
    logic [CRC_W-1:0]  poly;
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    int                ph;
    int                plen;
    int                nsearch;
    int                s;
    int                k;
    int                kind;
    int                tail;
    int                sel;
    bit                st;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_POLYNOMIAL;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_start_req = 1'b0;
    out_stall    = 1'b0;
    in_took      = 1'b0;
    steady       = 1'b0;
    idle_left    = 0;
    stall_left   = 0;
    queued_cnt   = 0;
    accepted_cnt = 0;
    mismatches   = 0;
    poly_cfg     = POLY_RESET;
    query_cfg    = '0;
    search_crc   = '0;
    search_count = '0;
    search_found = 1'b0;
    search_len   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset config: zero bytes keep the CRC at zero, so query zero hits repeatedly
    add_byte(8'h00, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h00, 1'b1);
    settle();

    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_POLYNOMIAL, '0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_byte(8'h00, 1'b0);
    settle();

    write_reg(REG_POLYNOMIAL, '1);
    write_reg(REG_QUERY_VALUE, '1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b0);
    settle();

    crc = crc_next_byte(crc_next_byte('0, 8'hFF, '1), 8'h00, '1);
    write_reg(REG_QUERY_VALUE, crc);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    settle();
    write_reg(REG_QUERY_VALUE, '0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h12, 1'b0);
    settle();

    for (ph = 0; queued_cnt < TARGET_BYTES; ph++) begin
      steady = (ph % 5 == 4);
      sel = $urandom_range(0, 9);
      case (sel)
        0:       poly = '0;
        1:       poly = '1;
        2:       poly = POLY_RESET;
        default: poly = {$urandom, $urandom};
      endcase
      plen = $urandom_range(1, 10);
      sel = $urandom_range(0, 5);
      crc = '0;
      for (k = 0; k < plen; k++) begin
        prefix[k] = (sel == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
        crc = crc_next_byte(crc, prefix[k], poly);
      end
      if ($urandom_range(0, 7) == 0) crc = {$urandom, $urandom};
      write_reg(REG_POLYNOMIAL, poly);
      write_reg(REG_QUERY_VALUE, crc);
      nsearch = $urandom_range(2, 5);
      for (s = 0; s < nsearch; s++) begin
        kind = $urandom_range(0, 9);
        for (k = 0; k < plen; k++) begin
          b = prefix[k];
          if (kind == 0 && $urandom_range(0, 3) == 0) b = b ^ (8'h01 << $urandom_range(0, 7));
          if (kind == 1) b = BYTE_W'($urandom_range(0, 255));
          st = (k == 0) && !(s == 0 && ph % 3 == 0);
          add_byte(b, st);
        end
        tail = $urandom_range(0, 12);
        for (k = 0; k < tail; k++) begin
          add_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 30) == 0);
        end
      end
      settle();
    end

    settle();
    repeat (3) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cpms_pkg.sv
rtl/cpms_crc_byte.sv
rtl/crc64_prefix_match_search_core.sv
rtl/cpms_checker.sv
tb/sv/crc64_prefix_match_search_core_tb.sv
